/* design/rmq_pkg.sv */
// Package for the rotation matrix to quaternion block.
// Holds widths, pipeline depths, axis codes and the inter-stage record types. No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int DW      = 32;             // field width
  localparam int RADW    = 35;             // radicand width (signed)
  localparam int SQW     = 64;             // radicand << 30
  localparam int ROOTW   = 32;             // root width
  localparam int NUMW    = 34;             // signed numerator width
  localparam int QW      = 33;             // quotient magnitude, capped at 2^31
  localparam int SQSTEPS = ROOTW;          // one root bit per stage
  localparam int DVSTEPS = QW;             // one quotient bit per stage
  // setup, root stages, divider setup, divider stages, output
  localparam int NSTG    = 1 + SQSTEPS + 1 + DVSTEPS + 1;

  // Branch codes: the axis of the largest diagonal entry, or the trace branch
  localparam logic [1:0] AX_X     = 2'd0;
  localparam logic [1:0] AX_Y     = 2'd1;
  localparam logic [1:0] AX_Z     = 2'd2;
  localparam logic [1:0] AX_TRACE = 2'd3;

  // Quantities computed up front and carried down the pipe.
  typedef struct packed {
    logic [1:0]              ax;      // AX_TRACE, else axis i
    logic                    zero;    // non-positive radicand
    logic [SQW-1:0]          rem;     // root remainder / radicand
    logic [ROOTW-1:0]        root;
    logic [2:0][NUMW-1:0]    num;     // numerators for the three quotients
  } sq_t;

  typedef struct packed {
    logic [1:0]              ax;
    logic                    zero;
    logic [ROOTW-1:0]        root;
    logic [2:0]              neg;
    logic [2:0]              ovf;     // quotient known to exceed the cap
    logic [2:0][QW-1:0]      dvd;     // low dividend bits still to shift in
    logic [2:0][ROOTW+1:0]   rem;     // partial remainders
    logic [2:0][QW-1:0]      quo;
  } dv_t;
endpackage

/* design/rmq_divider_stage.sv */
// One restoring divider step for three quotients sharing a divisor.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_divider_stage (
  input  rmq_pkg::dv_t d_in,
  output rmq_pkg::dv_t d_out
);
  logic [rmq_pkg::ROOTW+1:0] den;
  logic [rmq_pkg::ROOTW+2:0] trial;
  always_comb begin
    d_out = d_in;
    den   = {1'b0, d_in.root, 1'b0};
    trial = '0;
    for (int n = 0; n < 3; n++) begin
      // shift in next dividend bit, subtract if it fits
      trial = {d_in.rem[n], d_in.dvd[n][rmq_pkg::QW-1]};
      d_out.dvd[n] = {d_in.dvd[n][rmq_pkg::QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        d_out.rem[n] = (rmq_pkg::ROOTW+2)'(trial - {1'b0, den});
        d_out.quo[n] = {d_in.quo[n][rmq_pkg::QW-2:0], 1'b1};
      end else begin
        d_out.rem[n] = (rmq_pkg::ROOTW+2)'(trial);
        d_out.quo[n] = {d_in.quo[n][rmq_pkg::QW-2:0], 1'b0};
      end
    end
  end
endmodule

/* design/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, signed Q2.30, fully pipelined.
// Depends on rmq_pkg and rmq_divider_stage.
`timescale 1ns / 1ps
// A new matrix is accepted every cycle unless the pipe halts; its quaternion is
// registered at the output after 68 register stages (one setup stage, 32
// square-root stages at one root bit each, one divider setup stage, 33 divider
// stages at one quotient bit each, one output stage). The whole pipe halts
// when out_tready is low and the last stage holds an item; nothing is lost.
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // m00,m01,m02,m10,m11,m12,m20,m21,m22 (32 bits each, low to high)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x,quat_y,quat_z,quat_w (32 bits each, low to high)
  output logic [127:0] out_tdata
);
  localparam int DW = rmq_pkg::DW;
  localparam int SN = rmq_pkg::SQSTEPS;
  localparam int DN = rmq_pkg::DVSTEPS;

  logic adv;
  logic [SN:0] sv_r;
  logic [DN:0] dv_r;
  logic        ov_r;
  rmq_pkg::sq_t sq_r [SN+1];
  rmq_pkg::dv_t dq_r [DN+1];
  rmq_pkg::dv_t dq_nxt [DN];
  logic [127:0] out_r;

  assign adv        = !ov_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // ---- setup: trace, axis, radicand, numerators
  logic signed [DW-1:0] m [9];
  logic signed [rmq_pkg::RADW-1:0] tr, rad;
  logic [1:0] ax;
  rmq_pkg::sq_t s0;
  always_comb begin
    for (int n = 0; n < 9; n++) m[n] = in_tdata[n*DW +: DW];
    tr = rmq_pkg::RADW'(m[0]) + rmq_pkg::RADW'(m[4]) + rmq_pkg::RADW'(m[8]);
    if (m[0] < m[4]) ax = (m[4] < m[8]) ? rmq_pkg::AX_Z : rmq_pkg::AX_Y;
    else             ax = (m[0] < m[8]) ? rmq_pkg::AX_Z : rmq_pkg::AX_X;
    s0 = '0;
    if (tr > 0) begin
      s0.ax = rmq_pkg::AX_TRACE;
      rad = tr + (rmq_pkg::RADW'(1) <<< 30);
      s0.num[0] = rmq_pkg::NUMW'(m[7]) - rmq_pkg::NUMW'(m[5]);
      s0.num[1] = rmq_pkg::NUMW'(m[2]) - rmq_pkg::NUMW'(m[6]);
      s0.num[2] = rmq_pkg::NUMW'(m[3]) - rmq_pkg::NUMW'(m[1]);
    end else begin
      s0.ax = ax;
      case (ax)
        rmq_pkg::AX_X: begin
          rad = rmq_pkg::RADW'(m[0]) - rmq_pkg::RADW'(m[4]) - rmq_pkg::RADW'(m[8]);
          s0.num[0] = rmq_pkg::NUMW'(m[7]) - rmq_pkg::NUMW'(m[5]); // w
          s0.num[1] = rmq_pkg::NUMW'(m[3]) + rmq_pkg::NUMW'(m[1]); // y
          s0.num[2] = rmq_pkg::NUMW'(m[6]) + rmq_pkg::NUMW'(m[2]); // z
        end
        rmq_pkg::AX_Y: begin
          rad = rmq_pkg::RADW'(m[4]) - rmq_pkg::RADW'(m[8]) - rmq_pkg::RADW'(m[0]);
          s0.num[0] = rmq_pkg::NUMW'(m[2]) - rmq_pkg::NUMW'(m[6]); // w
          s0.num[1] = rmq_pkg::NUMW'(m[7]) + rmq_pkg::NUMW'(m[5]); // z
          s0.num[2] = rmq_pkg::NUMW'(m[1]) + rmq_pkg::NUMW'(m[3]); // x
        end
        default: begin
          rad = rmq_pkg::RADW'(m[8]) - rmq_pkg::RADW'(m[0]) - rmq_pkg::RADW'(m[4]);
          s0.num[0] = rmq_pkg::NUMW'(m[3]) - rmq_pkg::NUMW'(m[1]); // w
          s0.num[1] = rmq_pkg::NUMW'(m[2]) + rmq_pkg::NUMW'(m[6]); // x
          s0.num[2] = rmq_pkg::NUMW'(m[5]) + rmq_pkg::NUMW'(m[7]); // y
        end
      endcase
      rad = rad + (rmq_pkg::RADW'(1) <<< 30);
    end
    s0.zero = (rad <= 0);
    s0.rem  = s0.zero ? '0 : {rad[rmq_pkg::SQW-31:0], 30'd0};
  end

  // ---- square root, one result bit per stage (digit-by-digit)
  rmq_pkg::sq_t sq_nxt [SN];
  logic [rmq_pkg::ROOTW+1:0] st [SN];
  always_comb begin
    for (int n = 0; n < SN; n++) begin
      sq_nxt[n] = sq_r[n];
      // trial = (4*root+1) aligned at bit pair SN-1-n
      st[n] = {sq_r[n].root, 2'b01};
      if ((sq_r[n].rem >> (2*(SN-1-n))) >= rmq_pkg::SQW'(st[n])) begin
        sq_nxt[n].rem  = sq_r[n].rem - (rmq_pkg::SQW'(st[n]) << (2*(SN-1-n)));
        sq_nxt[n].root = {sq_r[n].root[rmq_pkg::ROOTW-2:0], 1'b1};
      end else begin
        sq_nxt[n].root = {sq_r[n].root[rmq_pkg::ROOTW-2:0], 1'b0};
      end
    end
  end

  // ---- divider setup from root stage
  // mag * 2^30 is split: mag >> 3 preloads the remainder and the low 33 bits
  // are shifted in; a preload not below the divisor means the quotient is
  // 2^33 or more, which is past the cap anyway
  rmq_pkg::dv_t d0;
  logic [rmq_pkg::NUMW-1:0] mg;
  logic [rmq_pkg::ROOTW:0]  dd;
  always_comb begin
    d0      = '0;
    d0.ax   = sq_r[SN].ax;
    d0.zero = sq_r[SN].zero;
    d0.root = sq_r[SN].root;
    dd      = {sq_r[SN].root, 1'b0};
    mg      = '0;
    for (int n = 0; n < 3; n++) begin
      d0.neg[n] = sq_r[SN].num[n][rmq_pkg::NUMW-1];
      mg = d0.neg[n] ? -sq_r[SN].num[n] : sq_r[SN].num[n];
      d0.rem[n] = {4'd0, mg[rmq_pkg::QW-1:3]};
      d0.dvd[n] = {mg[2:0], 30'd0};
      d0.ovf[n] = ({3'd0, mg[rmq_pkg::QW-1:3]} >= dd);
    end
  end

  for (genvar g = 0; g < DN; g++) begin : g_div
    rmq_divider_stage u_stg (.d_in(dq_r[g]), .d_out(dq_nxt[g]));
  end

  // ---- output: cap, sign, place components
  logic [3:0][DW-1:0] q;
  logic [2:0][DW-1:0] qs;
  logic [rmq_pkg::QW-1:0] qm;
  rmq_pkg::dv_t dl;
  always_comb begin
    dl = dq_r[DN];
    qm = '0;
    for (int n = 0; n < 3; n++) begin
      qm = (dl.ovf[n] || (dl.quo[n] > rmq_pkg::QW'(33'h80000000)))
           ? rmq_pkg::QW'(33'h80000000) : dl.quo[n];
      if (dl.neg[n]) qs[n] = DW'(-qm);
      else qs[n] = (qm[DW-1]) ? 32'h7FFFFFFF : qm[DW-1:0];
    end
    q = '0;
    case (dl.ax)
      rmq_pkg::AX_X: begin
        q[0] = {1'b0, dl.root[DW-1:1]}; q[3] = qs[0]; q[1] = qs[1]; q[2] = qs[2];
      end
      rmq_pkg::AX_Y: begin
        q[1] = {1'b0, dl.root[DW-1:1]}; q[3] = qs[0]; q[2] = qs[1]; q[0] = qs[2];
      end
      rmq_pkg::AX_Z: begin
        q[2] = {1'b0, dl.root[DW-1:1]}; q[3] = qs[0]; q[0] = qs[1]; q[1] = qs[2];
      end
      default: begin
        q[3] = {1'b0, dl.root[DW-1:1]}; q[0] = qs[0]; q[1] = qs[1]; q[2] = qs[2];
      end
    endcase
    if (dl.zero) q = '0;
  end

  // ---- pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      dv_r <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      sv_r <= {sv_r[SN-1:0], in_tvalid};
      dv_r <= {dv_r[DN-1:0], sv_r[SN]};
      ov_r <= dv_r[DN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= s0;
      for (int n = 0; n < SN; n++) sq_r[n+1] <= sq_nxt[n];
      dq_r[0] <= d0;
      for (int n = 0; n < DN; n++) dq_r[n+1] <= dq_nxt[n];
      out_r <= q;
    end
  end
endmodule

/* sim/tb_rotation_matrix_to_quaternion.sv */
// Testbench for the rotation matrix to quaternion block.
// Drives matrices through a stream port and checks each quaternion against a predictor.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
  localparam longint QONE = 64'sd1 << 30;
  localparam int     LATENCY = rmq_pkg::NSTG;
  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     N_RANDOM = 1400;

  typedef logic signed [rmq_pkg::DW-1:0] q30_t;
  typedef struct {
    q30_t m[3][3];
  } matrix_t;
  typedef struct packed {
    q30_t x, y, z, w;
  } quat_t;
  typedef struct {
    matrix_t mat;
    bit      has_quat;   // quaternion typed in by hand
    quat_t   quat;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  quat_t   quat_queue[$];
  int      n_errors;
  int      idle_cycles;
  bit      stalls_on;

  rotation_matrix_to_quaternion u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bitwise integer square root of a 64-bit value
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic q30_t clamp_q30(longint signed v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  // Saturated num * 2^30 / den, truncated toward zero
  function automatic q30_t q30_divide(longint signed num, longint unsigned den);
    bit              neg;
    longint unsigned mag;
    longint unsigned quo;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    quo = (mag << 30) / den;
    if (quo > 64'h80000000) quo = 64'h80000000;
    return clamp_q30(neg ? -longint'(quo) : longint'(quo));
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mx);
    longint signed   m[3][3];
    longint signed   tr;
    longint signed   rad;
    longint unsigned root;
    q30_t            c[4];
    int              i, j, k;
    quat_t           res;
    for (int r = 0; r < 3; r++)
      for (int cc = 0; cc < 3; cc++) m[r][cc] = mx.m[r][cc];
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = int_sqrt(longint'(tr + QONE) << 30);
      c[3] = clamp_q30(longint'(root >> 1));
      c[0] = q30_divide(m[2][1] - m[1][2], 2 * root);
      c[1] = q30_divide(m[0][2] - m[2][0], 2 * root);
      c[2] = q30_divide(m[1][0] - m[0][1], 2 * root);
    end else begin
      if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
      else i = (m[0][0] < m[2][2]) ? 2 : 0;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + QONE;
      if (rad <= 0) begin
        for (int n = 0; n < 4; n++) c[n] = '0;
      end else begin
        root = int_sqrt(longint'(rad) << 30);
        c[i] = clamp_q30(longint'(root >> 1));
        c[3] = q30_divide(m[k][j] - m[j][k], 2 * root);
        c[j] = q30_divide(m[j][i] + m[i][j], 2 * root);
        c[k] = q30_divide(m[k][i] + m[i][k], 2 * root);
      end
    end
    res.x = c[0];
    res.y = c[1];
    res.z = c[2];
    res.w = c[3];
    return res;
  endfunction

  function automatic matrix_t diag_matrix(q30_t a, q30_t b, q30_t cc);
    matrix_t mx;
    foreach (mx.m[r, c2]) mx.m[r][c2] = '0;
    mx.m[0][0] = a;
    mx.m[1][1] = b;
    mx.m[2][2] = cc;
    return mx;
  endfunction

  function automatic matrix_t fill_matrix(q30_t v);
    matrix_t mx;
    foreach (mx.m[r, c2]) mx.m[r][c2] = v;
    return mx;
  endfunction

  // Rotation-like entry: mostly within +-1.0, sometimes anything
  function automatic q30_t rand_entry(bit wild);
    if (wild) return $urandom;
    return q30_t'($urandom_range(0, 32'h8000_0000)) - q30_t'(32'h4000_0000);
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mx;
    int      mode;
    mode = $urandom_range(0, 9);
    foreach (mx.m[r, c2]) mx.m[r][c2] = rand_entry(mode == 0);
    // skew diagonal so every axis and the trace branch all get exercised
    if (mode >= 5 && mode <= 7) begin
      mx.m[mode - 5][mode - 5] = q30_t'($urandom_range(32'h3000_0000, 32'h4000_0000));
    end else if (mode == 8) begin
      mx.m[0][0] = mx.m[1][1];
      if ($urandom_range(0, 1)) mx.m[2][2] = mx.m[1][1];
    end
    return mx;
  endfunction

  function automatic matrix_t in_tdata_matrix();
    matrix_t mx;
    for (int r = 0; r < 3; r++)
      for (int c2 = 0; c2 < 3; c2++) mx.m[r][c2] = in_tdata[(r * 3 + c2) * 32 +: 32];
    return mx;
  endfunction

  // Push one matrix through the input port, honoring the handshake
  task automatic send_matrix(matrix_t mx);
    for (int r = 0; r < 3; r++)
      for (int c2 = 0; c2 < 3; c2++) in_tdata[(r * 3 + c2) * 32 +: 32] <= mx.m[r][c2];
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Receiver stall pattern: windows of random stalling and windows of none
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stalls_on = ~stalls_on;
      out_tready <= stalls_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Expected quaternions are formed as items are accepted
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      quat_queue = {quat_queue, matrix_to_quat(in_tdata_matrix())};
  end

  // Result checker
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[31:0];
      got.y = out_tdata[63:32];
      got.z = out_tdata[95:64];
      got.w = out_tdata[127:96];
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected quaternion %h", $time, out_tdata);
        n_errors++;
      end else begin
        want = quat_queue.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: quat_x expected %h actual %h", $time, want.x, got.x);
          n_errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: quat_y expected %h actual %h", $time, want.y, got.y);
          n_errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: quat_z expected %h actual %h", $time, want.z, got.z);
          n_errors++;
        end
        if (got.w !== want.w) begin
          $display("%0t: quat_w expected %h actual %h", $time, want.w, got.w);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    quat_t     zq;
    quat_t     hq;
    int        burst;
    n_errors    = 0;
    idle_cycles = 0;
    stalls_on   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;

    zq = '{x: '0, y: '0, z: '0, w: '0};
    // identity: root of trace plus one is 2.0, half is 1.0
    hq = '{x: '0, y: '0, z: '0, w: 32'h4000_0000};
    row = '{mat: diag_matrix(32'h4000_0000, 32'h4000_0000, 32'h4000_0000),
            has_quat: 1, quat: hq};
    table_rows = {table_rows, row};
    // all zero: trace zero takes axis branch, i = 0, radicand 1.0, qx = 0.5
    hq = '{x: 32'h2000_0000, y: '0, z: '0, w: '0};
    row = '{mat: fill_matrix('0), has_quat: 1, quat: hq};
    table_rows = {table_rows, row};
    // most negative diagonal entry against two near-maximal ones
    row = '{mat: diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
            has_quat: 0, quat: zq};
    table_rows = {table_rows, row};
    // half turns about each axis
    row = '{mat: diag_matrix(32'h4000_0000, 32'hC000_0000, 32'hC000_0000), has_quat: 0,
            quat: zq};
    table_rows = {table_rows, row};
    row.mat = diag_matrix(32'hC000_0000, 32'h4000_0000, 32'hC000_0000);
    table_rows = {table_rows, row};
    row.mat = diag_matrix(32'hC000_0000, 32'hC000_0000, 32'h4000_0000);
    table_rows = {table_rows, row};
    // ties on the diagonal
    row.mat = diag_matrix(32'hE000_0000, 32'hE000_0000, 32'hE000_0000);
    table_rows = {table_rows, row};
    row.mat = diag_matrix(32'hC000_0000, 32'hE000_0000, 32'hE000_0000);
    table_rows = {table_rows, row};
    // field extremes
    row.mat = fill_matrix(32'h7FFF_FFFF);
    table_rows = {table_rows, row};
    row.mat = fill_matrix(32'h8000_0000);
    table_rows = {table_rows, row};
    row.mat = fill_matrix(32'hFFFF_FFFF);
    table_rows = {table_rows, row};
    row.mat = fill_matrix(32'h0000_0001);
    table_rows = {table_rows, row};
    // big off-diagonals, so quotients can saturate
    row.mat = diag_matrix(32'hC000_0001, 32'h2000_0000, 32'h2000_0000);
    row.mat.m[0][1] = 32'h7FFF_FFFF;
    row.mat.m[1][0] = 32'h7FFF_FFFF;
    row.mat.m[2][0] = 32'h8000_0000;
    row.mat.m[0][2] = 32'h8000_0000;
    row.mat.m[2][1] = 32'h7FFF_FFFF;
    row.mat.m[1][2] = 32'h8000_0000;
    table_rows = {table_rows, row};
    row.mat.m[1][1] = 32'hC000_0000;
    row.mat.m[2][2] = 32'h4000_0001;
    table_rows = {table_rows, row};
    // trace just positive, large antisymmetric part
    row.mat = diag_matrix(32'h0000_0001, '0, '0);
    row.mat.m[2][1] = 32'h8000_0000;
    row.mat.m[1][2] = 32'h7FFF_FFFF;
    row.mat.m[0][2] = 32'h7FFF_FFFF;
    row.mat.m[2][0] = 32'h8000_0000;
    table_rows = {table_rows, row};
    // alternating bit patterns
    row.mat = fill_matrix(32'hAAAA_AAAA);
    table_rows = {table_rows, row};
    row.mat = fill_matrix(32'h5555_5555);
    table_rows = {table_rows, row};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    foreach (table_rows[n]) begin
      if (table_rows[n].has_quat) begin
        quat_t p;
        p = matrix_to_quat(table_rows[n].mat);
        if (p !== table_rows[n].quat) begin
          $display("%0t: row %0d expected %h actual %h", $time, n,
                   table_rows[n].quat, p);
          n_errors++;
        end
      end
      send_matrix(table_rows[n].mat);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    in_tvalid <= 1'b0;

    // sender holds off until the pipe has drained
    while (quat_queue.size() != 0) @(negedge clk);

    // random bursts
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 40);
      end
      send_matrix(rand_matrix());
      burst--;
    end
    in_tvalid <= 1'b0;

    while (quat_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

/* rotation_matrix_to_quaternion.f */
design/rmq_pkg.sv
design/rmq_divider_stage.sv
design/rotation_matrix_to_quaternion.sv
sim/tb_rotation_matrix_to_quaternion.sv
